@@ rtl/stbs_pkg.sv @@
// Shared types and constants for the sorted key table search block.
package stbs_pkg;

   localparam int KEY_W      = 32;
   localparam int INDEX_W    = 7;
   localparam int LENGTH_W   = 8;
   localparam int POSITION_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 1;

   // Command carried in req_tuser.
   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   // Configuration register addresses.
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_TABLE_LENGTH = 1'b0,
      REG_UNUSED       = 1'b1
   } csr_addr_type;

   typedef logic signed [KEY_W-1:0] key_type;

endpackage

@@ rtl/stbs_key_ram.sv @@
// Single-port-write, single-port-read key memory with registered read data.
module stbs_key_ram
   import stbs_pkg::*;
#(
   parameter int DEPTH = 128,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  key_type       wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output key_type       rd_data
);

   key_type mem [DEPTH];
   key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sorted_table_binary_search.sv @@
// Sorted key table with a binary search: a write command stores one signed
// 32-bit key in the table and returns nothing; a search command probes the
// first table_length entries (clamped to DEPTH) with a halving interval and
// returns one transaction on the rsp side: found in rsp_tuser and the 1-based
// matching slot (0 when not found) in rsp_tdata. The table is one memory with
// a registered read port, and each probe is a read (ST_PROBE) followed by a
// compare (ST_COMPARE). A search that misses ends on a probe step that sees
// the empty interval; a finished search waits for rsp_tready when the
// previous result is still unread. req_tready is high only while no search
// is running; a finished result sits in the output register and does not
// block new transactions. Keys must be sorted ascending and written before
// a search reads them; unwritten slots read as garbage. table_length is
// written over the APB-style port at byte address 0; the user must write
// it only while the block is idle, as the block does not enforce this.
module sorted_table_binary_search
   import stbs_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,   // entry_index[6:0], key_value[38:7], zero pad
   input  logic [0:0]            req_tuser,   // cmd[0]
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // position[7:0]
   output logic [0:0]            rsp_tuser,   // found[0]
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // Interval bounds run up to DEPTH itself (exclusive end).
   localparam int LW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_DONE
   } state_type;

   // Unpack the request transaction.
   logic [INDEX_W-1:0] req_entry_index;
   key_type            req_key_value;
   cmd_type            req_cmd;

   assign req_entry_index = req_tdata[INDEX_W-1:0];
   assign req_key_value   = req_tdata[INDEX_W +: KEY_W];
   assign req_cmd         = cmd_type'(req_tuser[0]);

   // Configuration register.
   logic [LENGTH_W-1:0] table_length_ff, table_length_in;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      table_length_in = table_length_ff;
      if (csr_write && csr_addr_type'(csr_paddr) == REG_TABLE_LENGTH) begin
         table_length_in = csr_pwdata[LENGTH_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_addr_type'(csr_paddr))
         REG_TABLE_LENGTH: csr_prdata = CSR_DATA_W'(table_length_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Search state.
   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff, found_in;
   logic [POSITION_W-1:0]  position_ff, position_in;
   logic                   done_found_ff, done_found_in;
   logic [POSITION_W-1:0]  done_position_ff, done_position_in;
   key_type                key_ff, key_in;
   logic [LW-1:0]          lo_ff, lo_in;
   logic [LW-1:0]          end_ff, end_in;
   logic [AW-1:0]          mid_ff, mid_in;

   logic                   req_accept;
   logic [31:0]            len_wide;
   logic [LW-1:0]          len_clamped;
   logic [LW:0]            mid_sum;
   logic [AW-1:0]          mid_next;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   key_type                ram_rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Clamp the table length to the memory depth.
   assign len_wide    = (32'(table_length_ff) > 32'(DEPTH)) ? 32'(DEPTH)
                                                             : 32'(table_length_ff);
   assign len_clamped = len_wide[LW-1:0];

   // Floor midpoint of the closed interval [lo, end-1].
   assign mid_sum  = ({1'b0, lo_ff} + {1'b0, end_ff} - (LW+1)'(1)) >> 1;
   assign mid_next = mid_sum[AW-1:0];

   // Drop writes aimed beyond the memory.
   assign ram_wr_en = req_accept && (req_cmd == CMD_WRITE) &&
                      (32'(req_entry_index) < 32'(DEPTH));
   assign ram_rd_en = (state_ff == ST_PROBE);

   stbs_key_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (req_key_value),
      .rd_en   (ram_rd_en),
      .rd_addr (mid_next),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff;
      found_in         = found_ff;
      position_in      = position_ff;
      done_found_in    = done_found_ff;
      done_position_in = done_position_ff;
      key_in           = key_ff;
      lo_in            = lo_ff;
      end_in           = end_ff;
      mid_in           = mid_ff;

      // Retire the held result once the sink takes it.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Start a search; writes complete in this cycle.
            if (req_accept && req_cmd == CMD_SEARCH) begin
               key_in   = req_key_value;
               lo_in    = '0;
               end_in   = len_clamped;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // Issue the read at the midpoint, or stop on an empty interval.
            if (lo_ff < end_ff) begin
               mid_in   = mid_next;
               state_in = ST_COMPARE;
            end else begin
               done_found_in    = 1'b0;
               done_position_in = '0;
               state_in         = ST_DONE;
            end
         end
         ST_COMPARE: begin
            // Narrow the interval toward the key.
            if (ram_rd_data == key_ff) begin
               done_found_in    = 1'b1;
               done_position_in = POSITION_W'(32'(mid_ff) + 32'd1);
               state_in         = ST_DONE;
            end else if (ram_rd_data < key_ff) begin
               lo_in    = LW'(32'(mid_ff) + 32'd1);
               state_in = ST_PROBE;
            end else begin
               end_in   = LW'(mid_ff);
               state_in = ST_PROBE;
            end
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               found_in     = done_found_ff;
               position_in  = done_position_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         table_length_ff <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         table_length_ff <= table_length_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff         <= found_in;
      position_ff      <= position_in;
      done_found_ff    <= done_found_in;
      done_position_ff <= done_position_in;
      key_ff           <= key_in;
      lo_ff            <= lo_in;
      end_ff           <= end_in;
      mid_ff           <= mid_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = position_ff;
   assign rsp_tuser[0] = found_ff;

endmodule

@@ sim/sorted_table_binary_search_tb.sv @@
// Self-checking testbench for the sorted key table binary search block.
`timescale 1ns / 100ps

module sorted_table_binary_search_tb;
   import stbs_pkg::*;

   localparam int TABLE_DEPTH    = 128;
   localparam int SETTLE_CYCLES  = 24;      // covers the longest search, with margin
   localparam int DRAIN_CYCLES   = 40;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DIRECTED_COUNT = 22;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_SEARCHES = 65;
   localparam int MAX_REPORTS    = 10;

   localparam key_type KEY_MIN = 32'sh8000_0000;
   localparam key_type KEY_MAX = 32'sh7FFF_FFFF;

   // One search answer as it leaves the block: found bit and 1-based slot.
   typedef struct packed {
      logic                  found;
      logic [POSITION_W-1:0] position;
   } search_result_type;

   // Directed row: optional table_length write before it, then one transaction.
   typedef struct packed {
      logic                set_len;
      logic [LENGTH_W-1:0] new_len;
      cmd_type             cmd;
      logic [INDEX_W-1:0]  slot;
      key_type             key;
      logic                typed;
      logic                exp_found;
      logic [7:0]          exp_pos;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata = '0;   // entry_index[6:0], key_value[38:7], zero pad
   logic [0:0]            req_tuser = '0;   // cmd[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // position[7:0]
   logic [0:0]            rsp_tuser;        // found[0]
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow of the block: key table and the table_length register.
   key_type             table_image [0:TABLE_DEPTH-1];
   logic [LENGTH_W-1:0] length_shadow = '0;

   search_result_type pending_search_results [$];

   int unsigned send_idle_pct  = 0;
   int unsigned stall_pct      = 0;
   int unsigned mismatch_count = 0;
   int unsigned search_count   = 0;
   int unsigned hit_count      = 0;
   int unsigned write_count    = 0;
   int unsigned cycle_count    = 0;

   // Directed stimulus. Rows with typed set carry an answer that is obvious
   // from the table contents; the rest go through the predictor.
   directed_row_type directed_rows [0:DIRECTED_COUNT-1] = '{
      // empty table after reset: nothing can be found
      '{1'b0, 8'd0, CMD_SEARCH, 7'd0,   KEY_MIN,        1'b1, 1'b0, 8'd0},
      '{1'b0, 8'd0, CMD_SEARCH, 7'h7F,  KEY_MAX,        1'b1, 1'b0, 8'd0},
      '{1'b0, 8'd0, CMD_SEARCH, 7'd5,   32'sd0,         1'b1, 1'b0, 8'd0},
      // load a small sorted table spanning the whole key range
      '{1'b0, 8'd0, CMD_WRITE,  7'd0,   KEY_MIN,        1'b0, 1'b0, 8'd0},
      '{1'b0, 8'd0, CMD_WRITE,  7'd1,   -32'sd1,        1'b0, 1'b0, 8'd0},
      '{1'b0, 8'd0, CMD_WRITE,  7'd2,   32'sd0,         1'b0, 1'b0, 8'd0},
      '{1'b0, 8'd0, CMD_WRITE,  7'd3,   KEY_MAX,        1'b0, 1'b0, 8'd0},
      '{1'b1, 8'd4, CMD_SEARCH, 7'd0,   KEY_MIN,        1'b1, 1'b1, 8'd1},
      '{1'b0, 8'd0, CMD_SEARCH, 7'h7F,  -32'sd1,        1'b1, 1'b1, 8'd2},
      '{1'b0, 8'd0, CMD_SEARCH, 7'd9,   32'sd0,         1'b1, 1'b1, 8'd3},
      '{1'b0, 8'd0, CMD_SEARCH, 7'd0,   KEY_MAX,        1'b1, 1'b1, 8'd4},
      // absent keys between stored neighbors
      '{1'b0, 8'd0, CMD_SEARCH, 7'd0,   32'sd1,         1'b1, 1'b0, 8'd0},
      '{1'b0, 8'd0, CMD_SEARCH, 7'd0,   32'sh8000_0001, 1'b1, 1'b0, 8'd0},
      // single-entry table hides everything past slot 0
      '{1'b1, 8'd1, CMD_SEARCH, 7'd0,   KEY_MIN,        1'b1, 1'b1, 8'd1},
      '{1'b0, 8'd0, CMD_SEARCH, 7'd0,   KEY_MAX,        1'b1, 1'b0, 8'd0},
      // writes to far slots, outside any search window here
      '{1'b0, 8'd0, CMD_WRITE,  7'h7F,  32'shAAAA_AAAA, 1'b0, 1'b0, 8'd0},
      '{1'b0, 8'd0, CMD_WRITE,  7'h40,  32'sh5555_5555, 1'b0, 1'b0, 8'd0},
      '{1'b1, 8'd2, CMD_SEARCH, 7'd0,   -32'sd1,        1'b1, 1'b1, 8'd2},
      // break the ordering: probe order alone decides the answer
      '{1'b0, 8'd0, CMD_WRITE,  7'd1,   KEY_MAX,        1'b0, 1'b0, 8'd0},
      '{1'b1, 8'd4, CMD_SEARCH, 7'd0,   32'sd0,         1'b0, 1'b0, 8'd0},
      '{1'b0, 8'd0, CMD_SEARCH, 7'd0,   KEY_MAX,        1'b0, 1'b0, 8'd0},
      // back to an empty table
      '{1'b1, 8'd0, CMD_SEARCH, 7'd0,   -32'sd1,        1'b1, 1'b0, 8'd0}
   };

   // Table lengths walked by the random phases; 255 checks the clamp to depth.
   int phase_lengths [0:PHASE_COUNT-1] = '{128, 255, 0, 1, 2, 5, 127, 16};

   sorted_table_binary_search #(
      .DEPTH(TABLE_DEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Result side back-pressure: stall at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Count every failure; print only the first few in full.
   function automatic void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
   endfunction

   // Walk the closed interval [lo, hi] exactly as the block does: floor
   // midpoint, stop on a match, otherwise step past the probe.
   function automatic search_result_type binary_search_result(key_type sought);
      int                lo;
      int                hi;
      int                mid;
      int                len;
      search_result_type answer;
      len    = (length_shadow > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_shadow);
      answer = '0;
      lo     = 0;
      hi     = len - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (table_image[mid] == sought) begin
            answer.found    = 1'b1;
            answer.position = 8'(mid + 1);
            return answer;
         end
         if (table_image[mid] < sought) begin
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      return answer;
   endfunction

   // Check each result transaction against the oldest prediction.
   always @(posedge clock) begin : result_check
      search_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser[0]) begin
            hit_count++;
         end
         if (pending_search_results.size() == 0) begin
            note_mismatch($sformatf("result with nothing expected: found=%0d position=%0d",
                                    rsp_tuser[0], rsp_tdata));
         end else begin
            want = pending_search_results.pop_front();
            if (rsp_tuser[0] !== want.found) begin
               note_mismatch($sformatf("found: expected %0d, got %0d", want.found,
                                       rsp_tuser[0]));
            end
            if (rsp_tdata !== want.position) begin
               note_mismatch($sformatf("position: expected %0d, got %0d", want.position,
                                       rsp_tdata));
            end
         end
      end
   end

   // Present one request transaction and hold it until it is taken. Drop
   // valid only when a gap is chosen, so back-to-back items keep it high.
   task automatic issue(cmd_type cmd, logic [INDEX_W-1:0] slot, key_type key);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, key, slot};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_WRITE) begin
         table_image[slot] = key;
         write_count++;
      end
   endtask

   // Issue a search and queue the predicted answer at the accepting edge.
   task automatic search_for(logic [INDEX_W-1:0] slot, key_type key);
      issue(CMD_SEARCH, slot, key);
      pending_search_results.push_back(binary_search_result(key));
      search_count++;
   endtask

   // Wait for the block to go idle, write table_length, then read it back.
   task automatic write_table_length(logic [LENGTH_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_search_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_TABLE_LENGTH;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      length_shadow = value;
      // read access right behind the write
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         note_mismatch($sformatf("table_length read back: expected %0d, got %0d", value,
                                 csr_prdata));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Fill slots 0..count-1 with ascending keys. Wide steps spread the keys
   // over the whole signed range; narrow steps pack neighbors and duplicates.
   task automatic fill_sorted(int count);
      longint span;
      longint start_room;
      longint level;
      if ($urandom_range(1) != 0) begin
         span = 64'd4294967295 / (count + 1);
      end else begin
         span = 3;
      end
      start_room = 64'd4294967295 - span * count;
      level      = -64'sd2147483648 + ({32'd0, $urandom()} % (start_room + 1));
      for (int s = 0; s < count; s++) begin
         issue(CMD_WRITE, INDEX_W'(s), key_type'(level[31:0]));
         level += $urandom_range(32'(span), 0);
      end
   endtask

   // One random phase: set the length, load a sorted table, then mostly
   // search for stored keys and their neighbors, with a few stray writes.
   task automatic run_phase(int len);
      int      count;
      int      roll;
      int      pick;
      key_type key;
      count = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
      write_table_length(LENGTH_W'(len));
      fill_sorted(count);
      for (int n = 0; n < PHASE_SEARCHES; ) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            // stray write: may break the ordering of the live window
            issue(CMD_WRITE, INDEX_W'($urandom_range(TABLE_DEPTH - 1)), key_type'($urandom()));
            continue;
         end
         pick = (count > 0) ? $urandom_range(count - 1) : 0;
         if (count > 0 && roll < 55) begin
            key = table_image[pick];
         end else if (count > 0 && roll < 80) begin
            key = ($urandom_range(1) != 0) ? table_image[pick] + 32'sd1
                                           : table_image[pick] - 32'sd1;
         end else if (roll < 86) begin
            key = ($urandom_range(1) != 0) ? KEY_MIN : KEY_MAX;
         end else begin
            key = key_type'($urandom());
         end
         search_for(INDEX_W'($urandom_range(TABLE_DEPTH - 1)), key);
         n++;
      end
   endtask

   initial begin : stimulus
      directed_row_type row;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling on either side
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = directed_rows[i];
         if (row.set_len) begin
            write_table_length(row.new_len);
         end
         if (row.cmd == CMD_WRITE) begin
            issue(row.cmd, row.slot, row.key);
         end else if (row.typed) begin
            issue(row.cmd, row.slot, row.key);
            pending_search_results.push_back(search_result_type'{row.exp_found,
                                                                  row.exp_pos});
            search_count++;
         end else begin
            search_for(row.slot, row.key);
         end
      end

      // random phases; the first one fills every slot, so no later search
      // can land on a slot that was never written
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 70;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 70;
            end
            default: begin
               send_idle_pct = 8;
               stall_pct     = 8;
            end
         endcase
         run_phase(phase_lengths[p]);
      end

      // drain: let every outstanding answer arrive, then watch for extras
      req_tvalid <= 1'b0;
      while (pending_search_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_search_results.size() != 0) begin
         note_mismatch($sformatf("%0d results never arrived", pending_search_results.size()));
      end

      $display("Ran %0d searches (%0d hits) and %0d table writes over %0d table lengths,",
               search_count, hit_count, write_count, PHASE_COUNT);
      $display("with idle and stall rates of 0, 8 and 70 percent; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("sorted_table_binary_search_tb passed");
      end else begin
         $display("sorted_table_binary_search_tb failed");
      end
      $finish;
   end

   // Hard stop if the block hangs.
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles", cycle_count);
      $display("sorted_table_binary_search_tb failed");
      $finish;
   end

endmodule
